@@ rtl/core/dash_pattern_stepper_defines.svh @@
// Assertion macros shared by the dash pattern stepper RTL.
`ifndef DASH_PATTERN_STEPPER_DEFINES_SVH
`define DASH_PATTERN_STEPPER_DEFINES_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge out of reset.
`define DPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never hold out of reset.
`define DPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DPS_ASSERT(label, clk, rst_n, prop, msg)
`define DPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/core/dps_pkg.sv @@
// Package with widths, register codes, types and helpers of the dash pattern stepper.
`default_nettype none
package dps_pkg;

  localparam int MAX_DASHES = 8;
  localparam int DIST_W     = 16;
  localparam int LEN_W      = 8;
  localparam int IDX_W      = 3;
  localparam int ENT_W      = 4;
  localparam int CNT_W      = 16;
  localparam int POS_W      = DIST_W + 1;
  localparam int TOT_W      = 11;
  localparam int BIT_W      = 5;
  localparam int LENS_W     = MAX_DASHES * LEN_W;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 64;

  // Register select, taken from paddr bit 3 (registers sit 8 bytes apart).
  localparam logic REG_LENGTHS = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  localparam logic [LENS_W-1:0] LENGTHS_RESET = 64'd1028;
  localparam logic [ENT_W-1:0]  ENTRIES_RESET = 4'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [LENS_W-1:0] lengths;
    logic [ENT_W-1:0]  entries;  // already clamped to 1..MAX_DASHES
  } cfg_t;

  function automatic logic [LEN_W-1:0] len_at(input logic [LENS_W-1:0] lens,
                                               input logic [IDX_W-1:0] idx);
    logic [LEN_W-1:0] v;
    v = lens[idx*LEN_W +: LEN_W];
    return (v == '0) ? LEN_W'(1) : v;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [ENT_W-1:0] n);
    logic [ENT_W-1:0] t;
    t = {1'b0, idx} + ENT_W'(1);
    return (t >= n) ? '0 : t[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/dash_pattern_stepper.sv @@
// Dash pattern stepper: advances a position along a repeating line-dash pattern.
//
// Usage. Each input transaction on the s_axis channel carries a pixel distance
// in tdata and a restart flag in tuser. Restart clears the dash index, the
// offset and the dash count before the step is applied. Every input transaction
// yields exactly one output transaction on m_axis with the new dash index,
// offset within the dash, the 16-bit wrapping dash count and the pen state.
// A step that stays inside the current dash goes from acceptance straight
// to the output state, ST_OUT. A step that leaves it runs one shared 17-bit
// add/subtract unit through period summing over the dashes in use, a
// bit-serial remainder of the overshoot and a dash walk, in the states
// ST_SUM, ST_MOD and ST_WALK, before it reaches ST_OUT.
// s_axis_tready is high only while the sequencer is idle; one item is in
// flight at a time. The result sits in an output register, so the next item
// is accepted while it waits; if the receiver still stalls when the next
// result is done, the sequencer holds it until the register frees up. Reset
// clears the position and loads two dashes of length 4. Configuration writes
// go through the APB-style port and must happen while the block is idle.
`default_nettype none
`include "dash_pattern_stepper_defines.svh"
module dash_pattern_stepper import dps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input stream.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [15:0] distance
  input  wire logic              s_axis_tuser,   // [0] restart
  // Output stream.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [2:0] dash_index_out, [10:3] offset_out, [26:11] dash_count_out,
  // [27] pen_on, [31:28] zero
  output logic [31:0]            m_axis_tdata,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  dps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  // Committed position.
  logic [IDX_W-1:0] idx_q;
  logic [LEN_W-1:0] off_q;
  logic [CNT_W-1:0] cnt_q;
  // Working registers of the long path.
  logic [IDX_W-1:0] widx_q;
  logic [CNT_W-1:0] wcnt_q;
  logic [POS_W-1:0] rem_q;
  logic [TOT_W-1:0] acc_q;   // pattern period
  logic [TOT_W-1:0] r_q;     // running remainder
  logic [BIT_W-1:0] bit_q;
  logic [IDX_W-1:0] sum_i_q;
  // Output register.
  logic             m_valid_q;
  logic [31:0]      m_data_q;

  logic             accept;
  logic [IDX_W-1:0] base_idx;
  logic [LEN_W-1:0] base_off;
  logic [CNT_W-1:0] base_cnt;
  logic [POS_W-1:0] pos;
  logic [TOT_W:0]   shifted;

  // Shared add/subtract unit; carry out of a subtract means a >= b.
  logic [POS_W-1:0] op_a, op_b;
  logic             op_sub;
  logic [POS_W:0]   alu_res;
  logic             alu_ge;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign base_idx = s_axis_tuser ? '0 : idx_q;
  assign base_off = s_axis_tuser ? '0 : off_q;
  assign base_cnt = s_axis_tuser ? '0 : cnt_q;
  assign pos      = POS_W'(base_off) + POS_W'(s_axis_tdata);
  assign shifted  = {r_q, rem_q[bit_q]};

  always_comb begin
    op_sub = 1'b1;
    op_a   = pos;
    op_b   = POS_W'(len_at(cfg.lengths, base_idx));
    case (state_q)
      ST_SUM: begin
        op_sub = 1'b0;
        op_a   = POS_W'(acc_q);
        op_b   = POS_W'(len_at(cfg.lengths, sum_i_q));
      end
      ST_MOD: begin
        op_a = POS_W'(shifted);
        op_b = POS_W'(acc_q);
      end
      ST_WALK: begin
        op_a = POS_W'(r_q);
        op_b = POS_W'(len_at(cfg.lengths, widx_q));
      end
      default: ;
    endcase
  end

  assign alu_res = {1'b0, op_a} + {1'b0, op_b ^ {POS_W{op_sub}}} + (POS_W+1)'(op_sub);
  assign alu_ge  = alu_res[POS_W];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = alu_ge ? ST_SUM : ST_OUT;
      end
      ST_SUM: begin
        if ({1'b0, sum_i_q} == cfg.entries - ENT_W'(1)) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (bit_q == '0) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!alu_ge) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      off_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result loads the output register as soon as it is free.
      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= base_idx;
            cnt_q <= base_cnt;
            off_q <= alu_ge ? base_off : pos[LEN_W-1:0];
          end
        end
        ST_WALK: begin
          // The walk ends on the first dash longer than what is left.
          if (!alu_ge) begin
            idx_q <= widx_q;
            off_q <= r_q[LEN_W-1:0];
            cnt_q <= wcnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rem_q   <= alu_res[POS_W-1:0];
          wcnt_q  <= base_cnt + CNT_W'(1);
          widx_q  <= next_idx(base_idx, cfg.entries);
          acc_q   <= '0;
          sum_i_q <= '0;
        end
      end
      ST_SUM: begin
        acc_q   <= alu_res[TOT_W-1:0];
        sum_i_q <= sum_i_q + IDX_W'(1);
        r_q     <= '0;
        bit_q   <= BIT_W'(POS_W-1);
      end
      ST_MOD: begin
        // Restoring remainder: one bit of the overshoot per cycle.
        r_q   <= alu_ge ? alu_res[TOT_W-1:0] : shifted[TOT_W-1:0];
        bit_q <= bit_q - BIT_W'(1);
      end
      ST_WALK: begin
        if (alu_ge) begin
          r_q    <= alu_res[TOT_W-1:0];
          wcnt_q <= wcnt_q + CNT_W'(1);
          widx_q <= next_idx(widx_q, cfg.entries);
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {4'b0, ~cnt_q[0], cnt_q, off_q, idx_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks on the sequencer.
  `DPS_ASSERT(a_one_item_in_flight, clk_i, rst_ni, accept |=> !s_axis_tready, "accepted while busy")
  `DPS_ASSERT(a_rem_below_period, clk_i, rst_ni, (state_q == ST_MOD || state_q == ST_WALK) |-> (r_q < acc_q), "remainder not below period")
  `DPS_ASSERT_NEVER(a_walk_index_range, clk_i, rst_ni, (state_q == ST_WALK) && ({1'b0, widx_q} >= cfg.entries), "walk index beyond list")

endmodule
`default_nettype wire

@@ rtl/core/dps_cfg.sv @@
// Configuration register file of the dash pattern stepper behind an APB-style port.
`default_nettype none
module dps_cfg import dps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [LENS_W-1:0] lengths_q;
  logic [ENT_W-1:0]  entries_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lengths_q <= LENGTHS_RESET;
      entries_q <= ENTRIES_RESET;
    end else if (wr_en) begin
      case (paddr[3])
        REG_LENGTHS: lengths_q <= pwdata[LENS_W-1:0];
        REG_ENTRIES: entries_q <= pwdata[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_LENGTHS: prdata = lengths_q;
      REG_ENTRIES: prdata = {{(APB_DW-ENT_W){1'b0}}, entries_q};
      default:     prdata = '0;
    endcase
  end

  // Zero entries act as one, anything above the list size as the full list.
  always_comb begin
    cfg_o.lengths = lengths_q;
    if (entries_q == '0) begin
      cfg_o.entries = ENT_W'(1);
    end else if (entries_q > ENT_W'(MAX_DASHES)) begin
      cfg_o.entries = ENT_W'(MAX_DASHES);
    end else begin
      cfg_o.entries = entries_q;
    end
  end

endmodule
`default_nettype wire

@@ dv/dash_pattern_stepper_tb.sv @@
// Self-checking testbench for the dash pattern stepper: directed table, then random phases.
`default_nettype none
module dash_pattern_stepper_tb;
  import dps_pkg::*;

  // Byte addresses of the two registers; they sit eight bytes apart.
  localparam logic [APB_AW-1:0] ADDR_LENGTHS = 4'h0;
  localparam logic [APB_AW-1:0] ADDR_ENTRIES = 4'h8;

  // A run with no transaction on any port for this many cycles is a hang.
  localparam int unsigned STALL_LIMIT = 4000;
  // Cycles allowed after the last result for stray output to show up.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned STEPS_PER_PHASE = 135;

  // One output transaction, split into its fields.
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] offset;
    logic [CNT_W-1:0] count;
    logic             pen;
  } step_result_t;

  typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_e;

  // A row of the directed table is either a register write or a step. Rows
  // marked as known carry an expectation worked out by hand; the others are
  // checked against the predictor.
  typedef struct packed {
    row_kind_e         kind;
    logic [APB_AW-1:0] addr;
    logic [APB_DW-1:0] value;
    logic [DIST_W-1:0] distance;
    logic              restart;
    logic              known;
    step_result_t      want;
  } row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;  // [15:0] distance
  logic              s_axis_tuser = 1'b0;  // [0] restart
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [2:0] dash index, [10:3] offset, [26:11] dash count, [27] pen on, [31:28] zero
  logic [31:0]       m_axis_tdata;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Predictor copy of the registers and of the pen position.
  logic [LENS_W-1:0] cfg_lengths = LENGTHS_RESET;
  logic [ENT_W-1:0]  cfg_entries = ENTRIES_RESET;
  logic [IDX_W-1:0]  pen_index = '0;
  logic [LEN_W-1:0]  pen_offset = '0;
  logic [CNT_W-1:0]  pen_count = '0;

  // Positions still owed by the block, oldest first.
  step_result_t pending_positions[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          sender_gaps = 1'b0;
  bit          stall_bursts = 1'b0;

  dash_pattern_stepper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Length of a dash in the current pattern; a zero length counts as one so
  // that the walk always terminates.
  function automatic int unsigned seg_len(input int unsigned idx);
    logic [LEN_W-1:0] b;
    b = cfg_lengths[idx*LEN_W +: LEN_W];
    return (b == '0) ? 1 : int'(b);
  endfunction

  // Next dash with wrap-around. An index left beyond a shortened list also
  // wraps to the first dash.
  function automatic int unsigned following_dash(input int unsigned idx, input int unsigned n);
    return (idx + 1 >= n) ? 0 : idx + 1;
  endfunction

  // Moves the predicted pen position by one step and returns the new position.
  function automatic step_result_t advance_pattern(input logic [DIST_W-1:0] distance,
                                                   input logic restart);
    int unsigned n, idx, pos, rem, total, i;
    logic [CNT_W-1:0] cnt;
    step_result_t r;
    // A count of zero means one dash; anything above eight means eight.
    n = (cfg_entries == '0) ? 1 : ((cfg_entries > MAX_DASHES) ? MAX_DASHES : cfg_entries);
    if (restart) begin
      pen_index = '0;
      pen_offset = '0;
      pen_count = '0;
    end
    idx = pen_index;
    cnt = pen_count;
    pos = pen_offset + distance;
    if (pos < seg_len(idx)) begin
      pen_offset = pos[LEN_W-1:0];
    end else begin
      // The overshoot is carried over even when the offset already lies
      // beyond a dash that was shortened.
      rem = pos - seg_len(idx);
      cnt = cnt + 1'b1;
      idx = following_dash(idx, n);
      total = 0;
      for (i = 0; i < n; i++) total += seg_len(i);
      // Whole periods are dropped without counting their dashes.
      if (total <= rem) rem = rem % total;
      while (rem >= seg_len(idx)) begin
        rem -= seg_len(idx);
        cnt = cnt + 1'b1;
        idx = following_dash(idx, n);
      end
      pen_index = idx[IDX_W-1:0];
      pen_offset = rem[LEN_W-1:0];
      pen_count = cnt;
    end
    r.index = pen_index;
    r.offset = pen_offset;
    r.count = pen_count;
    r.pen = ~pen_count[0];
    return r;
  endfunction

  function automatic row_t step_row(input logic [DIST_W-1:0] distance, input logic restart);
    row_t r;
    r = '0;
    r.kind = ROW_STEP;
    r.distance = distance;
    r.restart = restart;
    return r;
  endfunction

  function automatic row_t known_row(input logic [DIST_W-1:0] distance, input logic restart,
                                     input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] off,
                                     input logic [CNT_W-1:0] cnt, input logic pen);
    row_t r;
    r = step_row(distance, restart);
    r.known = 1'b1;
    r.want = '{index: idx, offset: off, count: cnt, pen: pen};
    return r;
  endfunction

  function automatic row_t write_row(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.addr = addr;
    r.value = value;
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input int unsigned want,
                                        input int unsigned got);
    if (mismatch_count < 10)
      $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
               results_seen, field, want, got);
    mismatch_count++;
  endfunction

  // Offers one step on the input stream, after an optional idle burst, and
  // records the expected position once the transaction is accepted.
  task automatic send_step(input logic [DIST_W-1:0] distance, input logic restart,
                           input logic known, input step_result_t want);
    int unsigned gap;
    step_result_t r;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = distance;
    s_axis_tuser = restart;
    do @(posedge clk_i); while (!s_axis_tready);
    r = advance_pattern(distance, restart);
    pending_positions.push_back(known ? want : r);
  endtask

  // Stops offering input and waits until every expected result has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
  endtask

  // Register write with a setup and an access cycle. Only called while idle.
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_LENGTHS) cfg_lengths = value[LENS_W-1:0];
    else cfg_entries = value[ENT_W-1:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Output stall bursts while they are enabled.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (stall_bursts && $urandom_range(0, 4) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Every accepted output transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_positions
    step_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.index = m_axis_tdata[2:0];
      got.offset = m_axis_tdata[10:3];
      got.count = m_axis_tdata[26:11];
      got.pen = m_axis_tdata[27];
      if (pending_positions.size() == 0) begin
        note_mismatch("unexpected result", 0, m_axis_tdata);
      end else begin
        want = pending_positions.pop_front();
        if (got.index != want.index) note_mismatch("dash index", want.index, got.index);
        if (got.offset != want.offset) note_mismatch("offset", want.offset, got.offset);
        if (got.count != want.count) note_mismatch("dash count", want.count, got.count);
        if (got.pen != want.pen) note_mismatch("pen on", want.pen, got.pen);
        if (m_axis_tdata[31:28] != '0) note_mismatch("padding", 0, m_axis_tdata[31:28]);
      end
      results_seen++;
    end
  end

  // Watchdog: any transaction on either stream or any write on the register
  // port counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t              rows[$];
    row_t              row;
    step_result_t      none;
    logic [LENS_W-1:0] lens;
    logic [ENT_W-1:0]  ents;
    logic [DIST_W-1:0] distance;
    int unsigned       phase, k, b;

    none = '0;

    // Directed table. The first four steps run on the reset pattern of two
    // dashes of length four, so their results are written out by hand.
    rows.push_back(known_row(16'd0, 1'b1, 3'd0, 8'd0, 16'd0, 1'b1));
    rows.push_back(known_row(16'd3, 1'b0, 3'd0, 8'd3, 16'd0, 1'b1));
    rows.push_back(known_row(16'd1, 1'b0, 3'd1, 8'd0, 16'd1, 1'b0));
    // The largest distance wraps through many whole periods without counting them.
    rows.push_back(known_row(16'hFFFF, 1'b0, 3'd0, 8'd3, 16'd2, 1'b1));
    // All dashes of length zero; the stored offset now lies past its dash.
    rows.push_back(write_row(ADDR_LENGTHS, 64'd0));
    rows.push_back(step_row(16'd5, 1'b0));
    rows.push_back(step_row(16'd0, 1'b0));
    // Eight dashes of the longest length, walked well into the list.
    rows.push_back(write_row(ADDR_LENGTHS, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(write_row(ADDR_ENTRIES, 64'd8));
    rows.push_back(step_row(16'hFFFF, 1'b1));
    rows.push_back(step_row(16'd600, 1'b0));
    // Shrinking the list leaves the current index beyond its end.
    rows.push_back(write_row(ADDR_ENTRIES, 64'd2));
    rows.push_back(step_row(16'd10, 1'b0));
    rows.push_back(step_row(16'd200, 1'b0));
    // An entry count of zero acts as one, and fifteen acts as eight.
    rows.push_back(write_row(ADDR_ENTRIES, 64'd0));
    rows.push_back(step_row(16'd7, 1'b0));
    rows.push_back(step_row(16'd300, 1'b0));
    rows.push_back(write_row(ADDR_ENTRIES, 64'd15));
    rows.push_back(write_row(ADDR_LENGTHS, 64'h0102_0003_0405_0007));
    rows.push_back(step_row(16'd1, 1'b0));
    rows.push_back(step_row(16'd2, 1'b0));
    rows.push_back(step_row(16'd50, 1'b0));
    rows.push_back(step_row(16'hFFFF, 1'b1));
    rows.push_back(write_row(ADDR_ENTRIES, 64'd1));
    rows.push_back(step_row(16'd300, 1'b1));
    rows.push_back(step_row(16'd0, 1'b0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sender_gaps = 1'b1;
    stall_bursts = 1'b1;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.addr, row.value);
      end else begin
        send_step(row.distance, row.restart, row.known, row.want);
      end
    end

    // Random phases, each under its own pattern. The first few pin the
    // extremes of both registers; the last two run without any idling.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (b = 0; b < MAX_DASHES; b++) begin
        case ($urandom_range(0, 5))
          0: lens[b*LEN_W +: LEN_W] = 8'd0;
          1: lens[b*LEN_W +: LEN_W] = 8'hFF;
          2, 3: lens[b*LEN_W +: LEN_W] = LEN_W'($urandom_range(1, 8));
          default: lens[b*LEN_W +: LEN_W] = LEN_W'($urandom_range(1, 255));
        endcase
      end
      ents = ($urandom_range(0, 3) == 0) ? ENT_W'($urandom_range(0, 15))
                                          : ENT_W'($urandom_range(1, 8));
      case (phase)
        0: begin lens = '0; ents = 4'd8; end
        1: begin lens = '1; ents = 4'd1; end
        2: ents = 4'd0;
        3: ents = 4'd15;
        default: ;
      endcase
      wait_drained();
      write_reg(ADDR_LENGTHS, 64'(lens));
      write_reg(ADDR_ENTRIES, 64'(ents));

      sender_gaps = (phase + 2 < RANDOM_PHASES) && ($urandom_range(0, 2) != 0);
      stall_bursts = (phase + 2 < RANDOM_PHASES) && ($urandom_range(0, 2) != 0);

      for (k = 0; k < STEPS_PER_PHASE; k++) begin
        // Let the pipeline run dry once in the middle of a phase.
        if (phase == 4 && k == STEPS_PER_PHASE / 2) wait_drained();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: distance = DIST_W'($urandom_range(0, 600));
          6, 7: distance = DIST_W'($urandom_range(0, 16));
          8: distance = DIST_W'($urandom);
          default: distance = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send_step(distance, $urandom_range(0, 9) == 0, 1'b0, none);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
